// ===== design/csem_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the counting semaphore table.
// No dependencies; imported by counting_semaphore_table_fifo_top.
package csem_pkg;

    localparam int IDX_W     = 4;
    localparam int COUNT_W   = 16;
    localparam int INIT_W    = 15;
    localparam int TID_W     = 6;
    localparam int INDEX_SPAN = 16;

    localparam int NUM_SEMAPHORES_DEF = 16;
    localparam int QUEUE_DEPTH_DEF    = 16;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_WAIT   = 2'd1,
        OP_SIGNAL = 2'd2,
        OP_FREE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_UNUSED = 2'd1,
        ST_NOFREE = 2'd2,
        ST_QFULL  = 2'd3
    } status_t;

    typedef struct packed {
        op_t               opcode;
        logic [IDX_W-1:0]  sem_index;
        logic [INIT_W-1:0] init_count;
        logic [TID_W-1:0]  thread_id;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  alloc_index;
        logic              blocked;
        logic              woken_valid;
        logic [TID_W-1:0]  woken_thread;
    } rsp_t;

endpackage

// ===== design/counting_semaphore_table_fifo_top.sv =====
`timescale 1ns / 1ps
// Counting semaphore table with per-entry FIFO wait queues.
// Depends on csem_pkg (types, opcodes, status codes, count limits).
//
// Usage:
//   req channel (req_valid / req_ready / req) carries one operation beat:
//   init, wait, signal or free. rsp channel (rsp_valid / rsp_ready / rsp)
//   returns exactly one result beat per request, in request order.
//   An accepted request waits in the request register until the result
//   register is empty or draining. Throughput: one operation per cycle
//   while rsp_ready holds. Each operation reads and rewrites one entry
//   (count, queue pointers, fill) in a single pass between the request
//   register and the result register; the waiter RAM read for a signal is
//   launched at acceptance so its registered data is ready by then.
//   Stall: when rsp_ready is low with a result pending, the request register
//   holds one more beat and req_ready drops; no state changes meanwhile.
//   Reset: every entry is marked free and both pipeline registers empty.
//   Count, pointers and the wait queue RAM are not cleared; init loads the
//   count and pointers before any wait or signal can reach the entry.
//   Only entries below both NUM_SEMAPHORES and 16 exist; an index beyond
//   them reads as an unused entry.
module counting_semaphore_table_fifo_top #(
    parameter int NUM_SEMAPHORES = csem_pkg::NUM_SEMAPHORES_DEF,
    parameter int QUEUE_DEPTH    = csem_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  csem_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output csem_pkg::rsp_t  rsp
);
    import csem_pkg::*;

    // Entries reachable by the 4-bit index.
    localparam int ENTRIES   = (NUM_SEMAPHORES < INDEX_SPAN) ? NUM_SEMAPHORES : INDEX_SPAN;
    localparam int ENT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = ENTRIES * QUEUE_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // Pipeline control
    logic                   req_valid_reg;
    req_t                   req_reg;
    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg;
    rsp_t                   rsp_next;
    logic                   exec_fire;
    logic                   req_fire;

    // Per-entry state
    logic [ENTRIES-1:0]         in_use_reg;
    logic signed [COUNT_W-1:0]  count_reg [ENTRIES];
    logic [PTR_W-1:0]           head_reg  [ENTRIES];
    logic [PTR_W-1:0]           tail_reg  [ENTRIES];
    logic [FILL_W-1:0]          fill_reg  [ENTRIES];

    // Waiter RAM and its read path
    logic [TID_W-1:0]       wait_mem [MEM_DEPTH];
    logic [TID_W-1:0]       rd_data_reg;
    logic                   byp_hit_reg;
    logic [TID_W-1:0]       byp_data_reg;
    logic [PTR_W-1:0]       head_cap_reg;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic                   mem_we;

    // Execute-stage signals
    logic [ENT_W-1:0]           e_ent;
    logic                       e_idx_ok;
    logic                       e_live;
    logic signed [COUNT_W-1:0]  e_count;
    logic [PTR_W-1:0]           e_tail;
    logic [FILL_W-1:0]          e_fill;
    logic                       free_found;
    logic [ENT_W-1:0]           free_idx;
    logic                       ent_we;
    logic [ENT_W-1:0]           ent_idx;
    logic signed [COUNT_W-1:0]  count_new;
    logic [PTR_W-1:0]           tail_new;
    logic [FILL_W-1:0]          fill_new;
    logic                       head_we;
    logic [PTR_W-1:0]           head_new;
    logic                       use_set;
    logic                       use_clr;
    logic [TID_W-1:0]           e_woken;

    // Request-side lookahead
    logic [ENT_W-1:0]       r_ent;
    logic [PTR_W-1:0]       head_fwd;

    function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    // Handshake: execute moves a held beat into the result register when
    // that register is empty or being drained this cycle.
    assign exec_fire = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || exec_fire;
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Execute-stage lookups: one entry, addressed by the held request.
    assign e_ent    = req_reg.sem_index[ENT_W-1:0];
    assign e_idx_ok = {1'b0, req_reg.sem_index} < (IDX_W + 1)'(ENTRIES);
    assign e_live   = e_idx_ok && in_use_reg[e_ent];
    assign e_count  = count_reg[e_ent];
    assign e_tail   = tail_reg[e_ent];
    assign e_fill   = fill_reg[e_ent];
    assign e_woken  = byp_hit_reg ? byp_data_reg : rd_data_reg;

    // Lowest free entry for init.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!free_found && !in_use_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = ENT_W'(i);
            end
        end
    end

    // Single-pass operation logic.
    always_comb
    begin
        rsp_next  = '0;
        ent_we    = 1'b0;
        ent_idx   = e_ent;
        count_new = e_count;
        tail_new  = e_tail;
        fill_new  = e_fill;
        head_we   = 1'b0;
        head_new  = ptr_step(head_cap_reg);
        use_set   = 1'b0;
        use_clr   = 1'b0;
        mem_we    = 1'b0;

        case (req_reg.opcode)
            OP_INIT:
            begin
                if (free_found)
                begin
                    rsp_next.status      = ST_OK;
                    rsp_next.alloc_index = IDX_W'(free_idx);
                    ent_we    = 1'b1;
                    ent_idx   = free_idx;
                    count_new = COUNT_W'(signed'({1'b0, req_reg.init_count}));
                    tail_new  = '0;
                    fill_new  = '0;
                    head_we   = 1'b1;
                    head_new  = '0;
                    use_set   = 1'b1;
                end
                else
                begin
                    rsp_next.status = ST_NOFREE;
                end
            end
            OP_WAIT:
            begin
                if (!e_live)
                begin
                    rsp_next.status = ST_UNUSED;
                end
                else
                begin
                    ent_we = 1'b1;
                    if (e_count != COUNT_MIN)
                        count_new = e_count - COUNT_W'(1);
                    // Blocking wait: enqueue unless the queue is full, then drop.
                    if (e_count <= 0)
                    begin
                        if (e_fill == FILL_W'(QUEUE_DEPTH))
                        begin
                            rsp_next.status = ST_QFULL;
                        end
                        else
                        begin
                            mem_we           = 1'b1;
                            tail_new         = ptr_step(e_tail);
                            fill_new         = e_fill + FILL_W'(1);
                            rsp_next.blocked = 1'b1;
                        end
                    end
                end
            end
            OP_SIGNAL:
            begin
                if (!e_live)
                begin
                    rsp_next.status = ST_UNUSED;
                end
                else
                begin
                    ent_we = 1'b1;
                    if (e_count != COUNT_MAX)
                        count_new = e_count + COUNT_W'(1);
                    if (e_fill != '0)
                    begin
                        head_we               = 1'b1;
                        fill_new              = e_fill - FILL_W'(1);
                        rsp_next.woken_valid  = 1'b1;
                        rsp_next.woken_thread = e_woken;
                    end
                end
            end
            OP_FREE:
            begin
                use_clr = e_idx_ok;
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    // Waiter RAM addresses: entry-major, one row of QUEUE_DEPTH slots each.
    assign wr_addr = ADDR_W'(ADDR_W'(e_ent) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(e_tail));

    // Head seen by the incoming beat: forward the update of the beat executing now.
    assign r_ent    = req.sem_index[ENT_W-1:0];
    assign head_fwd = (exec_fire && head_we && ent_idx == r_ent) ? head_new : head_reg[r_ent];
    assign rd_addr  = ADDR_W'(ADDR_W'(r_ent) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_fwd));

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            in_use_reg    <= '0;
        end
        else
        begin
            if (req_ready)
                req_valid_reg <= req_valid;
            if (exec_fire)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
            if (exec_fire && use_set)
                in_use_reg[ent_idx] <= 1'b1;
            if (exec_fire && use_clr)
                in_use_reg[e_ent] <= 1'b0;
        end
    end

    // Payload registers and per-entry state
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg      <= req;
            head_cap_reg <= head_fwd;
        end
        if (exec_fire)
            rsp_reg <= rsp_next;
        if (exec_fire && ent_we)
        begin
            count_reg[ent_idx] <= count_new;
            tail_reg[ent_idx]  <= tail_new;
            fill_reg[ent_idx]  <= fill_new;
        end
        if (exec_fire && head_we)
            head_reg[ent_idx] <= head_new;
    end

    // Waiter RAM: one write, one registered read launched at acceptance.
    // A same-edge write to the read slot is caught by the bypass register.
    always_ff @(posedge clk)
    begin
        if (exec_fire && mem_we)
            wait_mem[wr_addr] <= req_reg.thread_id;
        if (req_fire)
        begin
            rd_data_reg  <= wait_mem[rd_addr];
            byp_hit_reg  <= exec_fire && mem_we && (wr_addr == rd_addr);
            byp_data_reg <= req_reg.thread_id;
        end
    end

endmodule

// ===== dv/counting_semaphore_table_fifo_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for counting_semaphore_table_fifo_top: directed and random
// semaphore operations, each result checked against an in-bench semaphore table.
// Depends on csem_pkg (beat types, opcodes, status codes, count limits) and the RTL.
module counting_semaphore_table_fifo_top_tb;
    import csem_pkg::*;

    localparam int NUM_SEM     = NUM_SEMAPHORES_DEF;
    localparam int QDEPTH      = QUEUE_DEPTH_DEF;
    localparam int CLAIMABLE   = (NUM_SEM < INDEX_SPAN) ? NUM_SEM : INDEX_SPAN;
    localparam int RANDOM_OPS  = 1350;
    localparam int CALM_TAIL   = 150;   // last beats offered with no idling at all
    localparam int LONG_HOLD_AT = 500;  // result beat count that triggers the long hold
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 2000;  // cycles with no handshake before giving up
    localparam int PRINT_CAP   = 40;

    // One pending request beat; settle makes the sender wait for every result first.
    typedef struct packed {
        logic settle;
        req_t beat;
    } plan_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // Stimulus plan and the shadow of which entries the plan expects to be claimed.
    plan_t plan_q [$];
    logic  plan_live [INDEX_SPAN];
    logic  settle_next = 1'b0;
    int    useful_ops  = 0;

    // Semaphore table mirrored by the bench, updated at each accepted request beat.
    logic                      sem_live [NUM_SEM];
    logic signed [COUNT_W-1:0] sem_val  [NUM_SEM];
    logic [TID_W-1:0]          wq_ids   [NUM_SEM][QDEPTH];
    int                        wq_rd    [NUM_SEM];
    int                        wq_wr    [NUM_SEM];
    int                        wq_cnt   [NUM_SEM];
    rsp_t                      predicted_rsp_q [$];

    logic req_took     = 1'b0;
    int   gap_left     = 0;
    int   rx_hold      = 0;
    bit   long_hold_done = 1'b0;
    int   quiet_cycles = 0;

    int   req_beats = 0;
    int   rsp_beats = 0;
    int   mismatch_count = 0;
    int   n_blocked = 0;
    int   n_woken   = 0;
    int   n_qfull   = 0;
    int   n_nofree  = 0;
    int   n_unused  = 0;

    counting_semaphore_table_fifo_top #(
        .NUM_SEMAPHORES (NUM_SEM),
        .QUEUE_DEPTH    (QDEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Semaphore table prediction: apply one operation, return its result.
    // ------------------------------------------------------------------
    function automatic rsp_t apply_sem_op(req_t r);
        rsp_t o;
        int   s;
        int   k;
        logic sleeps;
        o = '0;
        s = int'(r.sem_index);
        case (r.opcode)
            OP_INIT:
            begin
                // claim the lowest free entry, fresh count and an empty queue
                o.status = ST_NOFREE;
                for (k = 0; k < CLAIMABLE; k++)
                begin
                    if (o.status == ST_NOFREE && !sem_live[k])
                    begin
                        sem_live[k]   = 1'b1;
                        sem_val[k]    = {1'b0, r.init_count};
                        wq_rd[k]      = 0;
                        wq_wr[k]      = 0;
                        wq_cnt[k]     = 0;
                        o.status      = ST_OK;
                        o.alloc_index = k[IDX_W-1:0];
                    end
                end
            end
            OP_WAIT:
            begin
                if (s >= NUM_SEM || !sem_live[s])
                    o.status = ST_UNUSED;
                else
                begin
                    // a count at or below zero puts the caller to sleep
                    sleeps = (sem_val[s] <= 0);
                    if (sem_val[s] != COUNT_MIN)
                        sem_val[s] = sem_val[s] - 16'sd1;
                    if (sleeps)
                    begin
                        if (wq_cnt[s] >= QDEPTH)
                            o.status = ST_QFULL;  // drop the waiter, count already moved
                        else
                        begin
                            wq_ids[s][wq_wr[s]] = r.thread_id;
                            wq_wr[s]  = (wq_wr[s] + 1) % QDEPTH;
                            wq_cnt[s] = wq_cnt[s] + 1;
                            o.blocked = 1'b1;
                        end
                    end
                end
            end
            OP_SIGNAL:
            begin
                if (s >= NUM_SEM || !sem_live[s])
                    o.status = ST_UNUSED;
                else
                begin
                    if (sem_val[s] != COUNT_MAX)
                        sem_val[s] = sem_val[s] + 16'sd1;
                    if (wq_cnt[s] > 0)
                    begin
                        o.woken_valid  = 1'b1;
                        o.woken_thread = wq_ids[s][wq_rd[s]];
                        wq_rd[s]  = (wq_rd[s] + 1) % QDEPTH;
                        wq_cnt[s] = wq_cnt[s] - 1;
                    end
                end
            end
            OP_FREE:
            begin
                if (s < NUM_SEM)
                    sem_live[s] = 1'b0;
            end
            default:
            begin
                o = '0;
            end
        endcase
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus planning helpers
    // ------------------------------------------------------------------
    function automatic int lowest_free();
        int k;
        for (k = 0; k < CLAIMABLE; k++)
        begin
            if (!plan_live[k])
                return k;
        end
        return -1;
    endfunction

    function automatic int pick_live();
        int live_q [$];
        int k;
        for (k = 0; k < INDEX_SPAN; k++)
        begin
            if (plan_live[k])
                live_q.insert(live_q.size(), k);
        end
        if (live_q.size() == 0)
            return -1;
        return live_q[$urandom_range(0, live_q.size() - 1)];
    endfunction

    // mostly tiny counts so waits block; sometimes wide or at the ceiling
    function automatic int pick_start();
        case ($urandom_range(0, 9))
            0:       return 32767;
            1, 2:    return $urandom_range(0, 32767);
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    task automatic plan_op(op_t op, int idx, int cnt, int tid);
        plan_t p;
        int    k;
        if (op == OP_INIT || plan_live[idx])
            useful_ops++;
        p.settle          = settle_next;
        p.beat.opcode     = op;
        p.beat.sem_index  = idx[IDX_W-1:0];
        p.beat.init_count = cnt[INIT_W-1:0];
        p.beat.thread_id  = tid[TID_W-1:0];
        settle_next       = 1'b0;
        if (op == OP_INIT)
        begin
            k = lowest_free();
            if (k >= 0)
                plan_live[k] = 1'b1;
        end
        else if (op == OP_FREE)
            plan_live[idx] = 1'b0;
        plan_q.insert(plan_q.size(), p);
    endtask

    // make sure an init will land somewhere; returns the entry it will claim
    task automatic claim_slot(output int slot);
        slot = lowest_free();
        if (slot < 0)
        begin
            slot = $urandom_range(0, CLAIMABLE - 1);
            plan_op(OP_FREE, slot, $urandom_range(0, 32767), $urandom_range(0, 63));
        end
    endtask

    // random idling, varied in phases so long runs with no idling occur too
    function automatic bit idle_now();
        if (plan_q.size() < CALM_TAIL)
            return 1'b0;
        case ((rsp_beats / 200) % 3)
            0:       return 1'b0;
            1:       return $urandom_range(0, 7) == 0;
            default: return $urandom_range(0, 2) == 0;
        endcase
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH at result beat %0d, %s: got 0x%0h, want 0x%0h",
                     rsp_beats, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the next planned beat at the falling edge and hold it
    // until accepted. Idle in random bursts; hold a settle beat until the
    // block has returned every result.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        plan_t nxt;
        logic  offer;
        if (rst_n)
        begin
            offer = req_valid && !req_took;
            if (!offer)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (plan_q.size() != 0)
                begin
                    if (plan_q[0].settle && predicted_rsp_q.size() != 0)
                        offer = 1'b0;
                    else if (idle_now())
                        gap_left = $urandom_range(0, 15);
                    else
                    begin
                        nxt   = plan_q[0];
                        plan_q.delete(0);
                        req   <= nxt.beat;
                        offer = 1'b1;
                    end
                end
            end
            req_valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: random stall bursts plus one long hold, so
    // the block fills and drops req_ready while the driver keeps offering.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold > 0)
            begin
                rx_hold--;
                rsp_ready <= 1'b0;
            end
            else if (!long_hold_done && rsp_beats >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                rx_hold = LONG_HOLD - 1;
                rsp_ready <= 1'b0;
            end
            else if (idle_now())
            begin
                rx_hold = $urandom_range(0, 15);
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict at each accepted request beat, check each result
    // beat field by field against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t want;
        req_took <= rst_n && req_valid && req_ready;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                predicted_rsp_q.insert(predicted_rsp_q.size(), apply_sem_op(req));
                req_beats++;
            end
            if (rsp_valid && rsp_ready)
            begin
                rsp_beats++;
                if (predicted_rsp_q.size() == 0)
                    flag_mismatch("result beat with nothing outstanding", int'(rsp), 0);
                else
                begin
                    want = predicted_rsp_q[0];
                    predicted_rsp_q.delete(0);
                    if (rsp.status !== want.status)
                        flag_mismatch("status", int'(rsp.status), int'(want.status));
                    if (rsp.alloc_index !== want.alloc_index)
                        flag_mismatch("alloc_index", int'(rsp.alloc_index),
                                      int'(want.alloc_index));
                    if (rsp.blocked !== want.blocked)
                        flag_mismatch("blocked", int'(rsp.blocked), int'(want.blocked));
                    if (rsp.woken_valid !== want.woken_valid)
                        flag_mismatch("woken_valid", int'(rsp.woken_valid),
                                      int'(want.woken_valid));
                    if (rsp.woken_thread !== want.woken_thread)
                        flag_mismatch("woken_thread", int'(rsp.woken_thread),
                                      int'(want.woken_thread));
                    n_blocked += want.blocked;
                    n_woken   += want.woken_valid;
                    n_qfull   += (want.status == ST_QFULL);
                    n_nofree  += (want.status == ST_NOFREE);
                    n_unused  += (want.status == ST_UNUSED);
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, predicted_rsp_q.size());
            $display("counting_semaphore_table_fifo_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Plan the stimulus, run reset, wait for completion and report.
    // ------------------------------------------------------------------
    initial
    begin
        int roll;
        int slot;
        int n;
        int c;
        int k;

        for (k = 0; k < INDEX_SPAN; k++)
            plan_live[k] = 1'b0;
        for (k = 0; k < NUM_SEM; k++)
            sem_live[k] = 1'b0;

        // Directed: errors on untouched entries, then the basic life cycle.
        plan_op(OP_WAIT,   0,  32767, 63);   // wait on an unused entry
        plan_op(OP_SIGNAL, 15, 0,     0);    // signal on an unused entry
        plan_op(OP_FREE,   9,  0,     0);    // free of an unused entry
        plan_op(OP_INIT,   0,  0,     0);    // entry 0, count zero
        plan_op(OP_INIT,   0,  32767, 0);    // entry 1, count at the ceiling
        plan_op(OP_INIT,   0,  1,     0);    // entry 2, count one
        plan_op(OP_WAIT,   0,  0,     63);   // block thread 63
        plan_op(OP_WAIT,   0,  0,     0);    // block thread 0
        plan_op(OP_SIGNAL, 0,  0,     0);    // wake 63 first
        plan_op(OP_SIGNAL, 0,  0,     0);    // then 0
        plan_op(OP_SIGNAL, 0,  0,     0);    // empty queue, count only
        plan_op(OP_SIGNAL, 1,  0,     0);    // count saturates at the top
        plan_op(OP_WAIT,   1,  0,     21);   // positive count, no block
        plan_op(OP_WAIT,   2,  0,     42);   // one to zero, no block
        plan_op(OP_WAIT,   2,  0,     42);   // zero, blocks
        plan_op(OP_FREE,   2,  0,     0);    // free with a waiter queued
        plan_op(OP_SIGNAL, 2,  0,     0);    // now unused
        plan_op(OP_WAIT,   2,  0,     0);
        plan_op(OP_INIT,   15, 21845, 63);   // reclaims entry 2, queue emptied
        plan_op(OP_SIGNAL, 2,  0,     0);    // no stale waiter left behind
        plan_op(OP_FREE,   0,  0,     0);
        plan_op(OP_FREE,   1,  0,     0);
        plan_op(OP_FREE,   2,  0,     0);
        plan_op(OP_FREE,   2,  0,     0);    // already unused
        plan_op(OP_INIT,   15, 10922, 42);   // index field ignored, claims 0

        // Random: mostly well-formed traffic on claimed entries, plus bursts
        // that fill a wait queue or the whole table, broken sequences and noise.
        settle_next = 1'b1;
        useful_ops  = 0;
        while (useful_ops < RANDOM_OPS)
        begin
            if ($urandom_range(0, 149) == 0)
                settle_next = 1'b1;
            roll = $urandom_range(0, 99);
            slot = pick_live();
            if (roll < 60 && slot >= 0)
                plan_op($urandom_range(0, 1) ? OP_WAIT : OP_SIGNAL, slot,
                        $urandom_range(0, 32767), $urandom_range(0, 63));
            else if (roll < 70 || slot < 0)
                plan_op(OP_INIT, $urandom_range(0, 15), pick_start(), $urandom_range(0, 63));
            else if (roll < 78)
                plan_op(OP_FREE, slot, $urandom_range(0, 32767), $urandom_range(0, 63));
            else if (roll < 85)
                plan_op(op_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                        $urandom_range(0, 32767), $urandom_range(0, 63));
            else if (roll < 92)
            begin
                // overfill one wait queue, then drain it
                claim_slot(slot);
                c = $urandom_range(0, 2);
                plan_op(OP_INIT, $urandom_range(0, 15), c, $urandom_range(0, 63));
                n = c + QDEPTH + $urandom_range(0, 3);
                for (k = 0; k < n; k++)
                    plan_op(OP_WAIT, slot, $urandom_range(0, 32767), $urandom_range(0, 63));
                n = $urandom_range(QDEPTH, n + 2);
                for (k = 0; k < n; k++)
                    plan_op(OP_SIGNAL, slot, $urandom_range(0, 32767), $urandom_range(0, 63));
                if ($urandom_range(0, 1))
                    plan_op(OP_FREE, slot, 0, $urandom_range(0, 63));
            end
            else if (roll < 96)
            begin
                // claim every entry, overflow the table, then release a few
                while (lowest_free() >= 0)
                    plan_op(OP_INIT, $urandom_range(0, 15), pick_start(), $urandom_range(0, 63));
                n = $urandom_range(1, 2);
                for (k = 0; k < n; k++)
                    plan_op(OP_INIT, $urandom_range(0, 15), pick_start(), $urandom_range(0, 63));
                n = $urandom_range(4, 12);
                for (k = 0; k < n; k++)
                    plan_op(OP_FREE, $urandom_range(0, 15), 0, 0);
            end
            else
            begin
                // use an entry right after releasing it
                plan_op(OP_FREE, slot, $urandom_range(0, 32767), $urandom_range(0, 63));
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                    plan_op($urandom_range(0, 1) ? OP_WAIT : OP_SIGNAL, slot,
                            $urandom_range(0, 32767), $urandom_range(0, 63));
            end
        end

        // Reset, then let the driver run down the plan.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (plan_q.size() != 0 || req_valid || predicted_rsp_q.size() != 0)
            @(posedge clk);
        // leave a margin for anything stray
        repeat (8) @(posedge clk);
        if (predicted_rsp_q.size() != 0)
            flag_mismatch("results never returned", 0, predicted_rsp_q.size());

        $display("ran %0d operations: %0d blocked waits, %0d wakeups, %0d queue-full drops",
                 req_beats, n_blocked, n_woken, n_qfull);
        $display("%0d inits on a full table, %0d ops on unused entries, %0d mismatches",
                 n_nofree, n_unused, mismatch_count);
        if (mismatch_count == 0)
            $display("counting_semaphore_table_fifo_top test passed");
        else
            $display("counting_semaphore_table_fifo_top test failed");
        $finish;
    end

endmodule
